### hw/rtl/cone_support_point_unit_macros.svh
// ----------------------------------------------------------------------------
// Cone support point unit: assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONE_SUPPORT_POINT_UNIT_MACROS_SVH
`define CONE_SUPPORT_POINT_UNIT_MACROS_SVH

// same-cycle implication
`define CSPU_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define CSPU_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/cspu_pkg.sv
// ----------------------------------------------------------------------------
// Cone support point unit: package
// Payload types, pipeline context and shared constants.
// ----------------------------------------------------------------------------
package cspu_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int SAT_W = (COORD_WIDTH < 2) ? 2 : ((COORD_WIDTH < 32) ? COORD_WIDTH : 32);

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  localparam logic signed [32:0] SAT_HI = (33'sd1 <<< (SAT_W - 1)) - 33'sd1;
  localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;

  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [47:0]        basis_row0;
    logic [47:0]        basis_row1;
    logic [47:0]        basis_row2;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
  } cspu_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               apex_chosen;
  } cspu_out_t;

  // per-item context that rides along the pipeline
  typedef struct packed {
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic signed [31:0] org_z;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic               rim;
  } cspu_ctx_t;

  function automatic logic signed [31:0] sat_coord(input logic signed [32:0] v);
    logic signed [32:0] c;
    c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return c[31:0];
  endfunction

endpackage

### hw/rtl/cspu_front.sv
// ----------------------------------------------------------------------------
// Cone support point unit: front end
// Rotates the direction, squares it and decides rim against apex (6 stages).
// ----------------------------------------------------------------------------
module cspu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  cspu_pkg::cspu_in_t  in_data,
  input  logic [30:0]         radius,
  input  logic [30:0]         height,
  input  logic [61:0]         r_sq,
  input  logic [61:0]         h_sq,
  output logic                out_valid,
  output cspu_pkg::cspu_ctx_t out_ctx,
  output logic [63:0]         out_s
);
  import cspu_pkg::*;

  function automatic logic signed [31:0] round_sat(input logic signed [49:0] acc);
    logic signed [49:0] sh;
    sh = (acc + 50'sd8192) >>> 14;
    if (sh > 50'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (sh < -50'sd2147483648) begin
      return 32'sh80000000;
    end
    return sh[31:0];
  endfunction

  logic [47:0]        row [3];
  logic signed [31:0] dir [3];

  assign row[0] = in_data.basis_row0;
  assign row[1] = in_data.basis_row1;
  assign row[2] = in_data.basis_row2;
  assign dir[0] = in_data.dir_x;
  assign dir[1] = in_data.dir_y;
  assign dir[2] = in_data.dir_z;

  // stage 1: products
  logic               v1_r;
  logic signed [47:0] prod1_r [3][3];
  logic signed [31:0] org1_r [3];

  // stage 2: rotated direction
  logic               v2_r;
  cspu_ctx_t          ctx2_r;
  logic signed [31:0] dz2_r;

  // stage 3: squares
  logic               v3_r;
  cspu_ctx_t          ctx3_r;
  logic [63:0]        sqx3_r, sqy3_r, sqz3_r;
  logic               dz_pos3_r, dz_neg3_r;

  // stage 4: xy length squared
  logic               v4_r;
  cspu_ctx_t          ctx4_r;
  logic [63:0]        s4_r, dzq4_r;
  logic               dz_pos4_r, dz_neg4_r;

  // stage 5: partial products of both sides
  logic               v5_r;
  cspu_ctx_t          ctx5_r;
  logic [63:0]        s5_r;
  logic               dz_pos5_r, dz_neg5_r;
  logic [63:0]        pa00_r, pa01_r, pa10_r, pa11_r;
  logic [63:0]        pb00_r, pb01_r, pb10_r, pb11_r;

  // stage 6: decision
  logic               v6_r;
  cspu_ctx_t          ctx6_r;
  logic [63:0]        s6_r;

  logic signed [31:0] d2_nxt [3];
  logic [31:0]        mag_x, mag_y, mag_z;
  logic [127:0]       lhs, rhs;
  logic               rim_nxt;
  cspu_ctx_t          ctx6_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d2_nxt[i] = round_sat(50'(prod1_r[i][0]) + 50'(prod1_r[i][1]) + 50'(prod1_r[i][2]));
    end
  end

  assign mag_x = ctx2_r.dx[31] ? 32'(-ctx2_r.dx) : 32'(ctx2_r.dx);
  assign mag_y = ctx2_r.dy[31] ? 32'(-ctx2_r.dy) : 32'(ctx2_r.dy);
  assign mag_z = dz2_r[31] ? 32'(-dz2_r) : 32'(dz2_r);

  assign lhs = (128'(pa11_r) << 63) + (128'(pa10_r) << 31) + (128'(pa01_r) << 32)
             + 128'(pa00_r);
  assign rhs = (128'(pb11_r) << 63) + (128'(pb10_r) << 31) + (128'(pb01_r) << 32)
             + 128'(pb00_r);

  always_comb begin
    if (s5_r == 64'd0) begin
      rim_nxt = 1'b0;
    end else if (dz_pos5_r) begin
      rim_nxt = lhs > rhs;
    end else begin
      rim_nxt = (radius != 31'd0) || ((height != 31'd0) && dz_neg5_r);
    end
    ctx6_nxt     = ctx5_r;
    ctx6_nxt.rim = rim_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod1_r[i][j] <= $signed(row[i][16*j +: 16]) * dir[j];
        end
      end
      org1_r[0] <= in_data.origin_x;
      org1_r[1] <= in_data.origin_y;
      org1_r[2] <= in_data.origin_z;

      ctx2_r <= '{org_x: org1_r[0], org_y: org1_r[1], org_z: org1_r[2],
                  dx: d2_nxt[0], dy: d2_nxt[1], rim: 1'b0};
      dz2_r  <= d2_nxt[2];

      ctx3_r    <= ctx2_r;
      sqx3_r    <= mag_x * mag_x;
      sqy3_r    <= mag_y * mag_y;
      sqz3_r    <= mag_z * mag_z;
      dz_pos3_r <= !dz2_r[31] && (dz2_r != 32'sd0);
      dz_neg3_r <= dz2_r[31];

      ctx4_r    <= ctx3_r;
      s4_r      <= sqx3_r + sqy3_r;
      dzq4_r    <= sqz3_r;
      dz_pos4_r <= dz_pos3_r;
      dz_neg4_r <= dz_neg3_r;

      // split as a1*2^31 + a0 against b1*2^32 + b0
      ctx5_r    <= ctx4_r;
      s5_r      <= s4_r;
      dz_pos5_r <= dz_pos4_r;
      dz_neg5_r <= dz_neg4_r;
      pa00_r    <= 64'(r_sq[30:0])  * 64'(s4_r[31:0]);
      pa01_r    <= 64'(r_sq[30:0])  * 64'(s4_r[63:32]);
      pa10_r    <= 64'(r_sq[61:31]) * 64'(s4_r[31:0]);
      pa11_r    <= 64'(r_sq[61:31]) * 64'(s4_r[63:32]);
      pb00_r    <= 64'(h_sq[30:0])  * 64'(dzq4_r[31:0]);
      pb01_r    <= 64'(h_sq[30:0])  * 64'(dzq4_r[63:32]);
      pb10_r    <= 64'(h_sq[61:31]) * 64'(dzq4_r[31:0]);
      pb11_r    <= 64'(h_sq[61:31]) * 64'(dzq4_r[63:32]);

      ctx6_r <= ctx6_nxt;
      s6_r   <= s5_r;
    end
  end

  assign out_valid = v6_r;
  assign out_ctx   = ctx6_r;
  assign out_s     = s6_r;

endmodule

### hw/rtl/cspu_sqrt.sv
// ----------------------------------------------------------------------------
// Cone support point unit: square root
// Pipelined 64-bit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cspu_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  cspu_pkg::cspu_ctx_t in_ctx,
  input  logic [63:0]         in_s,
  output logic                out_valid,
  output cspu_pkg::cspu_ctx_t out_ctx,
  output logic [31:0]         out_len,
  output logic [63:0]         out_rem
);
  import cspu_pkg::*;

  logic        vld_r [SQRT_STEPS];
  cspu_ctx_t   ctx_r [SQRT_STEPS];
  logic [63:0] rem_r [SQRT_STEPS];
  logic [63:0] root_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic        vld_in;
    cspu_ctx_t   ctx_in;
    logic [63:0] rem_in, root_in, trial;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign ctx_in  = in_ctx;
      assign rem_in  = in_s;
      assign root_in = 64'd0;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign ctx_in  = ctx_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign trial = root_in + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[k] <= ctx_in;
        if (rem_in >= trial) begin
          rem_r[k]  <= rem_in - trial;
          root_r[k] <= (root_in >> 1) + BIT;
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in >> 1;
        end
      end
    end
  end

  assign out_valid = vld_r[SQRT_STEPS-1];
  assign out_ctx   = ctx_r[SQRT_STEPS-1];
  assign out_len   = root_r[SQRT_STEPS-1][31:0];
  assign out_rem   = rem_r[SQRT_STEPS-1];

endmodule

### hw/rtl/cspu_div.sv
// ----------------------------------------------------------------------------
// Cone support point unit: rim scaling
// Forms radius*|d| and divides it by the xy length, one quotient bit a stage.
// ----------------------------------------------------------------------------
module cspu_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  cspu_pkg::cspu_ctx_t in_ctx,
  input  logic [31:0]         in_len,
  input  logic [30:0]         radius,
  output logic                out_valid,
  output cspu_pkg::cspu_ctx_t out_ctx,
  output logic [31:0]         out_len,
  output logic [30:0]         out_qx,
  output logic [30:0]         out_qy
);
  import cspu_pkg::*;

  logic [31:0] mag_x, mag_y;

  // numerator stage
  logic        np_vld_r;
  cspu_ctx_t   np_ctx_r;
  logic [31:0] np_len_r;
  logic [62:0] np_x_r, np_y_r;

  logic        vld_r [DIV_STEPS];
  cspu_ctx_t   ctx_r [DIV_STEPS];
  logic [31:0] len_r [DIV_STEPS];
  logic [62:0] rx_r [DIV_STEPS];
  logic [62:0] ry_r [DIV_STEPS];
  logic [30:0] qx_r [DIV_STEPS];
  logic [30:0] qy_r [DIV_STEPS];

  assign mag_x = in_ctx.dx[31] ? 32'(-in_ctx.dx) : 32'(in_ctx.dx);
  assign mag_y = in_ctx.dy[31] ? 32'(-in_ctx.dy) : 32'(in_ctx.dy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      np_vld_r <= 1'b0;
    end else if (en) begin
      np_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      np_ctx_r <= in_ctx;
      np_len_r <= in_len;
      np_x_r   <= 63'(radius) * 63'(mag_x);
      np_y_r   <= 63'(radius) * 63'(mag_y);
    end
  end

  // quotient stays within the radius, so 31 bits cover it
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    localparam int SH = DIV_STEPS - 1 - i;
    logic        vld_in;
    cspu_ctx_t   ctx_in;
    logic [31:0] len_in;
    logic [62:0] rx_in, ry_in, dvs;
    logic [30:0] qx_in, qy_in;

    if (i == 0) begin : g_first
      assign vld_in = np_vld_r;
      assign ctx_in = np_ctx_r;
      assign len_in = np_len_r;
      assign rx_in  = np_x_r;
      assign ry_in  = np_y_r;
      assign qx_in  = 31'd0;
      assign qy_in  = 31'd0;
    end else begin : g_next
      assign vld_in = vld_r[i-1];
      assign ctx_in = ctx_r[i-1];
      assign len_in = len_r[i-1];
      assign rx_in  = rx_r[i-1];
      assign ry_in  = ry_r[i-1];
      assign qx_in  = qx_r[i-1];
      assign qy_in  = qy_r[i-1];
    end

    assign dvs = 63'(len_in) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[i] <= ctx_in;
        len_r[i] <= len_in;
        if (rx_in >= dvs) begin
          rx_r[i] <= rx_in - dvs;
          qx_r[i] <= qx_in | (31'd1 << SH);
        end else begin
          rx_r[i] <= rx_in;
          qx_r[i] <= qx_in;
        end
        if (ry_in >= dvs) begin
          ry_r[i] <= ry_in - dvs;
          qy_r[i] <= qy_in | (31'd1 << SH);
        end else begin
          ry_r[i] <= ry_in;
          qy_r[i] <= qy_in;
        end
      end
    end
  end

  assign out_valid = vld_r[DIV_STEPS-1];
  assign out_ctx   = ctx_r[DIV_STEPS-1];
  assign out_len   = len_r[DIV_STEPS-1];
  assign out_qx    = qx_r[DIV_STEPS-1];
  assign out_qy    = qy_r[DIV_STEPS-1];

endmodule

### hw/rtl/cone_support_point_unit.sv
// Support point of a posed cone: one request per clock unless in_stall holds;
// a result passes 6 front stages for rotation, squaring and the rim/apex
// decision, 32 square-root stages, 32 scaling stages, one output stage. The
// depth is set by the square root and the rim division, one bit per stage each.
// While out_stall holds a waiting result the whole pipeline freezes, and
// in_stall follows. Radius and height are written through the cfg port, which
// is always ready; write them only while no request is in flight.
// ----------------------------------------------------------------------------
// Cone support point unit: top level
// Config registers, pipeline control and the final offset and saturation.
// ----------------------------------------------------------------------------
module cone_support_point_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  cspu_pkg::cspu_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output cspu_pkg::cspu_out_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cspu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data
);
  import cspu_pkg::*;

  logic [30:0] radius_r, height_r;
  logic [61:0] r_sq_r, h_sq_r;
  logic        en;

  logic        fr_valid;
  cspu_ctx_t   fr_ctx;
  logic [63:0] fr_s;

  logic        sq_valid;
  cspu_ctx_t   sq_ctx;
  logic [31:0] sq_len;
  logic [63:0] sq_rem;

  logic        dv_valid;
  cspu_ctx_t   dv_ctx;
  logic [31:0] dv_len;
  logic [30:0] dv_qx, dv_qy;

  logic        out_valid_r;
  cspu_out_t   out_data_r, out_data_nxt;
  logic signed [31:0] cand_x, cand_y, cand_z;

  // advance unless a finished result is held
  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 31'd65536;
      height_r <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RADIUS: radius_r <= cfg_data[30:0];
        CFG_HEIGHT: height_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r_sq_r <= 62'(radius_r) * 62'(radius_r);
    h_sq_r <= 62'(height_r) * 62'(height_r);
  end

  cspu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .radius    (radius_r),
    .height    (height_r),
    .r_sq      (r_sq_r),
    .h_sq      (h_sq_r),
    .out_valid (fr_valid),
    .out_ctx   (fr_ctx),
    .out_s     (fr_s)
  );

  cspu_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_ctx    (fr_ctx),
    .in_s      (fr_s),
    .out_valid (sq_valid),
    .out_ctx   (sq_ctx),
    .out_len   (sq_len),
    .out_rem   (sq_rem)
  );

  cspu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_ctx    (sq_ctx),
    .in_len    (sq_len),
    .radius    (radius_r),
    .out_valid (dv_valid),
    .out_ctx   (dv_ctx),
    .out_len   (dv_len),
    .out_qx    (dv_qx),
    .out_qy    (dv_qy)
  );

  always_comb begin
    if (dv_ctx.rim) begin
      cand_x = dv_ctx.dx[31] ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
      cand_y = dv_ctx.dy[31] ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
      cand_z = 32'sd0;
    end else begin
      cand_x = 32'sd0;
      cand_y = 32'sd0;
      cand_z = $signed({1'b0, height_r});
    end
    out_data_nxt.point_x     = sat_coord(33'(dv_ctx.org_x) + 33'(cand_x));
    out_data_nxt.point_y     = sat_coord(33'(dv_ctx.org_y) + 33'(cand_y));
    out_data_nxt.point_z     = sat_coord(33'(dv_ctx.org_z) + 33'(cand_z));
    out_data_nxt.apex_chosen = !dv_ctx.rim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "cone_support_point_unit_macros.svh"

  `CSPU_ASSERT_IMPL(a_rim_needs_len, fr_valid && fr_ctx.rim, fr_s != 64'd0, "rim chosen with zero xy length")
  `CSPU_ASSERT_IMPL(a_sqrt_rem, sq_valid, sq_rem <= {31'd0, sq_len, 1'b0}, "square root remainder too large")
  `CSPU_ASSERT_IMPL(a_div_len, dv_valid && dv_ctx.rim, dv_len != 32'd0, "rim scaled by zero length")
  `CSPU_ASSERT_NEXT(a_rsq_track, 1'b1, r_sq_r == 62'($past(radius_r)) * 62'($past(radius_r)), "radius square stale")

endmodule

### dv/cone_support_point_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cone support point checker
// Watches the request and result channels and the register port, predicts
// each support point from its own model of the cone and compares in order.
// ----------------------------------------------------------------------------
module cone_support_point_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  cspu_pkg::cspu_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  cspu_pkg::cspu_out_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [cspu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  fail_count,
  output int                  pending_points
);
  import cspu_pkg::*;

  logic [30:0] radius_q;
  logic [30:0] height_q;
  cspu_out_t   point_queue[$];

  function automatic logic signed [63:0] clamp_s(input logic signed [63:0] v, input int w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic cspu_out_t support_point(input cspu_in_t q);
    logic signed [63:0]  dir[3];
    logic signed [63:0]  org[3];
    logic signed [63:0]  rot[3];
    logic signed [63:0]  cand[3];
    logic [47:0]         row[3];
    logic signed [63:0]  acc;
    logic signed [15:0]  ent;
    logic [63:0]         s;
    logic [127:0]        lhs;
    logic [127:0]        rhs;
    logic signed [63:0]  r;
    logic signed [63:0]  h;
    logic signed [63:0]  len;
    logic                rim;
    cspu_out_t           res;
    dir[0] = q.dir_x; dir[1] = q.dir_y; dir[2] = q.dir_z;
    org[0] = q.origin_x; org[1] = q.origin_y; org[2] = q.origin_z;
    row[0] = q.basis_row0; row[1] = q.basis_row1; row[2] = q.basis_row2;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        ent = row[i][16*j +: 16];
        acc = acc + 64'(ent) * dir[j];
      end
      // round half up to Q16.16 (arithmetic shift floors)
      rot[i] = clamp_s((acc + 64'sd8192) >>> 14, 32);
    end
    s = 64'(rot[0] * rot[0]) + 64'(rot[1] * rot[1]);
    r = 64'(radius_q);
    h = 64'(height_q);
    if (s == 0) rim = 1'b0;
    else if (rot[2] > 0) begin
      lhs = 128'(64'(r * r)) * 128'(s);
      rhs = 128'(64'(h * h)) * 128'(64'(rot[2] * rot[2]));
      rim = lhs > rhs;
    end else rim = (r > 0) || (h > 0 && rot[2] < 0);
    if (rim) begin
      len = $signed(root_floor(s));
      cand[0] = (r * rot[0]) / len;
      cand[1] = (r * rot[1]) / len;
      cand[2] = 0;
    end else begin
      cand[0] = 0; cand[1] = 0; cand[2] = h;
    end
    res.point_x = 32'(clamp_s(org[0] + cand[0], SAT_W));
    res.point_y = 32'(clamp_s(org[1] + cand[1], SAT_W));
    res.point_z = 32'(clamp_s(org[2] + cand[2], SAT_W));
    res.apex_chosen = !rim;
    return res;
  endfunction

  always_ff @(posedge clk) begin
    cspu_out_t exp_pt;
    if (!rst_n) begin
      radius_q <= 31'd65536;
      height_q <= 31'd65536;
      fail_count <= 0;
      point_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_RADIUS) radius_q <= cfg_data[30:0];
        else if (cfg_index == CFG_HEIGHT) height_q <= cfg_data[30:0];
      end
      if (in_valid && !in_stall) point_queue.push_back(support_point(in_data));
      if (out_valid && !out_stall) begin
        if (point_queue.size() == 0) begin
          $display("%0t: unexpected point, expected none, actual %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_pt = point_queue.pop_front();
          if (exp_pt !== out_data) begin
            $display("%0t: point mismatch, expected x=%h y=%h z=%h apex=%b, actual x=%h y=%h z=%h apex=%b",
                     $time, exp_pt.point_x, exp_pt.point_y, exp_pt.point_z, exp_pt.apex_chosen,
                     out_data.point_x, out_data.point_y, out_data.point_z,
                     out_data.apex_chosen);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending_points = point_queue.size();

endmodule

### dv/cone_support_point_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cone support point unit testbench
// Directed and random pose queries under several radius and height settings,
// with random gaps and stalls on both channels; results checked in order.
// ----------------------------------------------------------------------------
module cone_support_point_unit_tb;
  import cspu_pkg::*;

  localparam int PIPE_DEPTH = 71;
  localparam int IDLE_LIMIT = 20000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  cspu_in_t   in_data;
  logic       out_valid;
  logic       out_stall;
  cspu_out_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  int         fail_count;
  int         pending_points;
  int         quiet_cycles;
  bit         hold_off;

  cone_support_point_unit DUT (.*);

  cone_support_point_checker u_checker (.*);

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off && !held) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        held = 1'b1;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("FAIL cone_support_point_unit");
      $finish;
    end
  end

  function automatic logic [15:0] basis_entry(input int mode);
    case (mode)
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'h0000;
      3: return 16'h7FFF;
      4: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] coord_val(input int mode);
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(0, 131072)) - 65536);
      default: return (mode == 0) ? $urandom : 32'($signed($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  function automatic cspu_in_t random_query();
    cspu_in_t q;
    int m;
    q.dir_x = coord_val(0);
    q.dir_y = coord_val(1);
    q.dir_z = coord_val(1);
    m = $urandom_range(0, 6);
    q.basis_row0 = {basis_entry(m), basis_entry(m), basis_entry(m)};
    q.basis_row1 = {basis_entry(m), basis_entry(m), basis_entry(m)};
    q.basis_row2 = {basis_entry(m), basis_entry(m), basis_entry(m)};
    if ($urandom_range(0, 2) == 0) begin
      // plain identity rotation
      q.basis_row0 = {16'h0, 16'h0, 16'h4000};
      q.basis_row1 = {16'h0, 16'h4000, 16'h0};
      q.basis_row2 = {16'h4000, 16'h0, 16'h0};
    end
    q.origin_x = coord_val(1);
    q.origin_y = coord_val(0);
    q.origin_z = coord_val($urandom_range(0, 1));
    return q;
  endfunction

  task automatic send_query(input cspu_in_t q);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_points != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 8) @(negedge clk);
  endtask

  initial begin
    cspu_in_t q;
    logic [31:0] radii[6];
    logic [31:0] heights[6];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RADIUS;
    cfg_data = '0;
    hold_off = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: identity pose, apex on zero xy, ties, extremes
    for (int k = 0; k < 20; k++) begin
      q = '0;
      q.basis_row0 = {16'h0, 16'h0, 16'h4000};
      q.basis_row1 = {16'h0, 16'h4000, 16'h0};
      q.basis_row2 = {16'h4000, 16'h0, 16'h0};
      case (k)
        0: q.dir_z = 32'sh10000;
        1: q.dir_z = -32'sh10000;
        2: q.dir_x = 32'sh10000;
        3: begin q.dir_x = 32'sh10000; q.dir_z = 32'sh10000; end
        4: begin q.dir_x = 32'sh7FFF_FFFF; q.dir_y = 32'sh7FFF_FFFF; q.dir_z = 32'sh7FFF_FFFF; end
        5: begin q.dir_x = 32'sh8000_0000; q.dir_y = 32'sh8000_0000; end
        6: begin q.dir_x = 32'sh10000; q.origin_x = 32'sh7FFF_FFFF; end
        7: begin q.dir_x = -32'sh10000; q.origin_x = 32'sh8000_0000; end
        8: begin q.dir_z = 32'sh10000; q.origin_z = 32'sh7FFF_FFFF; end
        9: begin
          q.dir_x = 32'sh7FFF_FFFF; q.dir_y = 32'sh7FFF_FFFF; q.dir_z = 32'sh7FFF_FFFF;
          q.basis_row0 = {3{16'h7FFF}};
          q.basis_row1 = {3{16'h8000}};
          q.basis_row2 = {3{16'h8000}};
        end
        10: q.dir_y = 32'sh1;
        11: begin q.dir_x = 32'sh1; q.dir_z = 32'sh7FFF_FFFF; end
        default: q = random_query();
      endcase
      send_query(q);
    end
    drain();

    radii = '{32'h0, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0, 32'hFFFF_FFFF, 32'h0003_8000};
    heights = '{32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0002_0000, 32'hFFFF_FFFF, 32'h0000_4000};
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_RADIUS, radii[p]);
      write_reg(CFG_HEIGHT, heights[p]);
      for (int n = 0; n < 180; n++) begin
        if (p == 2 && n == 40) hold_off = 1'b1;
        send_query(random_query());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS cone_support_point_unit");
    end else begin
      $display("FAIL cone_support_point_unit");
    end
    $finish;
  end

endmodule
